// ===== rtl/core/fpa_pkg.sv =====
// Package: shared types, opcodes and constants for the Q24.8 ALU core.
`timescale 1ns / 1ps
package fpa_pkg;
	localparam int FracBits = 8;
	localparam int DataW    = 32;
	localparam int NumW     = DataW + FracBits;   // |a<<8| magnitude width
	localparam int QW       = NumW;               // quotient magnitude width
	localparam int Stages   = QW;                 // one quotient bit per cell

	typedef enum logic [3:0] {
		OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3,
		OP_EQ = 4'd4, OP_NE = 4'd5, OP_GT = 4'd6, OP_LT = 4'd7,
		OP_GE = 4'd8, OP_LE = 4'd9, OP_MIN = 4'd10, OP_MAX = 4'd11,
		OP_INC = 4'd12, OP_DEC = 4'd13, OP_FROMINT = 4'd14, OP_TOINT = 4'd15
	} op_t;

	typedef struct packed {
		logic [3:0]         op;
		logic signed [31:0] operand_a;
		logic signed [31:0] operand_b;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] value;
		logic               cond_true;
		logic               div_zero;
	} out_item_t;

	// Token carried down the cell chain.
	typedef struct packed {
		logic              vld;
		logic              is_div;
		logic              neg;       // quotient sign
		logic [DataW-1:0]  res;       // precomputed non-divide value
		logic              cond;
		logic              dz;
		logic [DataW-1:0]  dvs;       // |b|
		logic [DataW:0]    rem;       // partial remainder
		logic [NumW-1:0]   num;       // dividend bits shifting out / quotient in
	} cell_tok_t;
endpackage

// ===== rtl/core/fixed_point_q24_8_alu_core.sv =====
// Module: top level of the Q24.8 fixed-point ALU core.
// Pipeline: every operation passes from the start transfer through
//   1 decode/multiply stage, 40 division cells and 1 output register to its result.
// Throughput: one transfer per cycle; busy is tied low since the chain never stalls.
// Division runs as a chain of cells, each resolving one quotient bit per cycle.
// Reset: arst_n clears all valid flags; done stays low until the first result.
`timescale 1ns / 1ps
module fixed_point_q24_8_alu_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  fpa_pkg::in_item_t   in_item,
	output logic                done,
	output fpa_pkg::out_item_t  out_item
);
	fpa_pkg::cell_tok_t chain [fpa_pkg::Stages+1];
	logic [fpa_pkg::QW-1:0] q;
	logic [31:0] qv;

	assign busy = 1'b0;

	fpa_front u_front (
		.clk(clk), .arst_n(arst_n), .take(start && !busy),
		.item(in_item), .tok(chain[0])
	);

	for (genvar i = 0; i < fpa_pkg::Stages; i++) begin : g_cell
		fpa_cell u_cell (
			.clk(clk), .arst_n(arst_n),
			.tok_in(chain[i]), .tok_out(chain[i+1])
		);
	end

	// Quotient sign fix-up, low 32 bits kept.
	assign q  = chain[fpa_pkg::Stages].num;
	assign qv = chain[fpa_pkg::Stages].neg ? (32'd0 - q[31:0]) : q[31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= chain[fpa_pkg::Stages].vld;
		end
	end

	always_ff @(posedge clk) begin
		out_item.value     <= chain[fpa_pkg::Stages].is_div ? qv : chain[fpa_pkg::Stages].res;
		out_item.cond_true <= chain[fpa_pkg::Stages].cond;
		out_item.div_zero  <= chain[fpa_pkg::Stages].dz;
	end

	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(out_item.cond_true && out_item.div_zero))
		else $error("cond and div_zero both set");
	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && out_item.div_zero |-> out_item.value == 32'sd0)
		else $error("div by zero value nonzero");
	a_cmp_val: assert property (@(posedge clk) disable iff (!arst_n)
		done && out_item.cond_true |-> out_item.value == 32'sd1)
		else $error("compare value not 1");
endmodule

// ===== rtl/core/fpa_cell.sv =====
// Module: one restoring-division cell, one quotient bit per cycle.
`timescale 1ns / 1ps
module fpa_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  fpa_pkg::cell_tok_t  tok_in,
	output fpa_pkg::cell_tok_t  tok_out
);
	fpa_pkg::cell_tok_t nxt;
	logic [fpa_pkg::DataW:0]   trial;
	logic [fpa_pkg::DataW+1:0] diff;

	always_comb begin
		nxt   = tok_in;
		trial = {tok_in.rem[fpa_pkg::DataW-1:0], tok_in.num[fpa_pkg::NumW-1]};
		diff  = {1'b0, trial} - {2'b00, tok_in.dvs};
		if (tok_in.is_div) begin
			nxt.rem = diff[fpa_pkg::DataW+1] ? trial : diff[fpa_pkg::DataW:0];
			nxt.num = {tok_in.num[fpa_pkg::NumW-2:0], ~diff[fpa_pkg::DataW+1]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_out <= '0;
		end else begin
			tok_out <= nxt;
		end
	end
endmodule

// ===== rtl/core/fpa_front.sv =====
// Module: operand decode, simple ops, and multiplier/divider setup stage.
`timescale 1ns / 1ps
module fpa_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                take,
	input  fpa_pkg::in_item_t   item,
	output fpa_pkg::cell_tok_t  tok
);
	logic signed [31:0] a, b;
	logic [31:0] ua, ub, res, abs_a, abs_b;
	logic signed [63:0] prod_s1;
	logic               mul_s1;
	fpa_pkg::cell_tok_t t_s1;
	logic lt, gt, eq, isc;

	assign a = item.operand_a;
	assign b = item.operand_b;
	assign ua = a;
	assign ub = b;
	assign lt = a < b;
	assign gt = a > b;
	assign eq = a == b;
	assign abs_a = a[31] ? (32'd0 - ua) : ua;
	assign abs_b = b[31] ? (32'd0 - ub) : ub;

	always_comb begin
		res = '0;
		isc = 1'b0;
		case (fpa_pkg::op_t'(item.op))
			fpa_pkg::OP_ADD:     res = ua + ub;
			fpa_pkg::OP_SUB:     res = ua - ub;
			fpa_pkg::OP_EQ:      isc = eq;
			fpa_pkg::OP_NE:      isc = !eq;
			fpa_pkg::OP_GT:      isc = gt;
			fpa_pkg::OP_LT:      isc = lt;
			fpa_pkg::OP_GE:      isc = !lt;
			fpa_pkg::OP_LE:      isc = !gt;
			fpa_pkg::OP_MIN:     res = lt ? ua : ub;
			fpa_pkg::OP_MAX:     res = gt ? ua : ub;
			fpa_pkg::OP_INC:     res = ua + 32'd1;
			fpa_pkg::OP_DEC:     res = ua - 32'd1;
			fpa_pkg::OP_FROMINT: res = ua << fpa_pkg::FracBits;
			fpa_pkg::OP_TOINT:   res = 32'(a >>> fpa_pkg::FracBits);
			default:             res = '0;
		endcase
		if (isc) res = 32'd1;
	end

	// Stage 1: multiply registered; divide token built.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			t_s1 <= '0;
		end else begin
			t_s1.vld    <= take;
			t_s1.is_div <= (item.op == fpa_pkg::OP_DIV) && (b != 0);
			t_s1.dz     <= (item.op == fpa_pkg::OP_DIV) && (b == 0);
			t_s1.neg    <= a[31] ^ b[31];
			t_s1.res    <= res;
			t_s1.cond   <= isc;
			t_s1.dvs    <= abs_b;
			t_s1.rem    <= '0;
			t_s1.num    <= {abs_a, {fpa_pkg::FracBits{1'b0}}};
		end
	end

	always_ff @(posedge clk) begin
		mul_s1  <= item.op == fpa_pkg::OP_MUL;
		prod_s1 <= a * b;
	end

	always_comb begin
		tok = t_s1;
		if (mul_s1) tok.res = prod_s1[fpa_pkg::FracBits +: 32];
	end
endmodule
